// File: src/ubxack_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubxack_pkg
// shared codes and constants of the acknowledge frame checker
// ----------------------------------------------------------------------------
package ubxack_pkg;

  // frame layout
  localparam int FRAME_BYTES = 10;
  localparam int POS_W       = $clog2(FRAME_BYTES);

  localparam logic [POS_W-1:0] POS_SYNC_FIRST  = POS_W'(0);
  localparam logic [POS_W-1:0] POS_SYNC_SECOND = POS_W'(1);
  localparam logic [POS_W-1:0] POS_ACK_CLASS   = POS_W'(2);
  localparam logic [POS_W-1:0] POS_ACK_ID      = POS_W'(3);
  localparam logic [POS_W-1:0] POS_MSG_CLASS   = POS_W'(6);
  localparam logic [POS_W-1:0] POS_MSG_ID      = POS_W'(7);
  localparam logic [POS_W-1:0] POS_CHECK_A     = POS_W'(FRAME_BYTES - 2);

  // item kinds
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_BYTE  = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  // result codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_TIMEOUT  = 2'd1;
  localparam logic [1:0] STATUS_NAK      = 2'd2;
  localparam logic [1:0] STATUS_MISMATCH = 2'd3;

  // register indexes
  localparam logic [1:0] REG_TIMEOUT_MS  = 2'd0;
  localparam logic [1:0] REG_SYNC_FIRST  = 2'd1;
  localparam logic [1:0] REG_SYNC_SECOND = 2'd2;
  localparam logic [1:0] REG_ACK_CLASS   = 2'd3;

  // register reset values
  localparam logic [15:0] TIMEOUT_MS_RST  = 16'd1500;
  localparam logic [7:0]  SYNC_FIRST_RST  = 8'hB5;
  localparam logic [7:0]  SYNC_SECOND_RST = 8'h62;
  localparam logic [7:0]  ACK_CLASS_RST   = 8'h05;

endpackage

// File: src/ubx_ack_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubx_ack_frame_checker
// receives one acknowledge frame byte by byte and reports its verdict
// ----------------------------------------------------------------------------
// a result beat is registered in the output register, or in the skid entry on a stall
// throughput: one item per cycle, set by the single register stage of the
//   frame state; a two-entry result buffer keeps input flowing while the
//   output side stalls, input stalls only when both entries are full
// reset: synchronous, active high; registers return to their defaults,
//   the checker is disarmed and no result is pending
module ubx_ack_frame_checker
  import ubxack_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // item channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [7:0]  data_byte,
  input  logic [7:0]  expect_class,
  input  logic [7:0]  expect_id,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  // register write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // configuration registers
  logic [15:0] timeout_ms;
  logic [7:0]  sync_first;
  logic [7:0]  sync_second;
  logic [7:0]  ack_class;

  // frame state
  logic             armed, armed_next;
  logic [POS_W-1:0] position, position_next;
  logic [15:0]      elapsed_ms, elapsed_ms_next;
  logic [7:0]       want_class, want_class_next;
  logic [7:0]       want_id, want_id_next;
  logic [7:0]       sum_a, sum_a_next;
  logic [7:0]       sum_b, sum_b_next;
  logic [7:0]       got_ack_id, got_ack_id_next;
  logic [7:0]       got_class, got_class_next;
  logic [7:0]       got_msg_id, got_msg_id_next;
  logic [7:0]       got_check_a, got_check_a_next;

  // result buffer: output register plus a skid entry behind it
  logic       skid_valid;
  logic [1:0] skid_status;

  logic       in_beat;
  logic       res_valid;
  logic [1:0] res_status;
  logic [7:0] sum_a_add;
  logic [7:0] sum_b_add;
  logic [15:0] elapsed_inc;

  // the skid entry only fills while the output register is held
  assign in_ready  = !skid_valid;
  assign in_beat   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // fletcher-8 step on the incoming byte
  assign sum_a_add   = sum_a + data_byte;
  assign sum_b_add   = sum_b + sum_a_add;
  assign elapsed_inc = elapsed_ms + 16'd1;

  // ---------------------------------------------------------------------------
  // next frame state and result for one accepted beat
  // ---------------------------------------------------------------------------
  always_comb begin
    armed_next       = armed;
    position_next    = position;
    elapsed_ms_next  = elapsed_ms;
    want_class_next  = want_class;
    want_id_next     = want_id;
    sum_a_next       = sum_a;
    sum_b_next       = sum_b;
    got_ack_id_next  = got_ack_id;
    got_class_next   = got_class;
    got_msg_id_next  = got_msg_id;
    got_check_a_next = got_check_a;
    res_valid        = 1'b0;
    res_status       = STATUS_OK;

    if (in_beat) begin
      unique case (kind)
        KIND_START: begin
          // arm and clear the frame, also when already armed
          want_class_next  = expect_class;
          want_id_next     = expect_id;
          armed_next       = 1'b1;
          position_next    = POS_SYNC_FIRST;
          elapsed_ms_next  = '0;
          sum_a_next       = '0;
          sum_b_next       = '0;
          got_ack_id_next  = 8'd1;
          got_class_next   = '0;
          got_msg_id_next  = '0;
          got_check_a_next = '0;
        end
        KIND_TICK: begin
          if (armed) begin
            elapsed_ms_next = elapsed_inc;
            if (elapsed_inc >= timeout_ms) begin
              armed_next = 1'b0;
              res_valid  = 1'b1;
              res_status = STATUS_TIMEOUT;
            end
          end
        end
        KIND_BYTE: begin
          if (armed) begin
            // header bytes that do not match are skipped, the count is kept
            priority if (position == POS_SYNC_FIRST) begin
              if (data_byte == sync_first) position_next = POS_SYNC_SECOND;
            end else if (position == POS_SYNC_SECOND) begin
              if (data_byte == sync_second) position_next = POS_ACK_CLASS;
            end else if (position == POS_ACK_CLASS) begin
              if (data_byte == ack_class) begin
                sum_a_next    = sum_a_add;
                sum_b_next    = sum_b_add;
                position_next = POS_ACK_ID;
              end
            end else if (position < POS_CHECK_A) begin
              // ack id, length and payload bytes all go into the sum
              sum_a_next    = sum_a_add;
              sum_b_next    = sum_b_add;
              position_next = position + POS_W'(1);
              if (position == POS_ACK_ID)    got_ack_id_next = data_byte;
              if (position == POS_MSG_CLASS) got_class_next  = data_byte;
              if (position == POS_MSG_ID)    got_msg_id_next = data_byte;
            end else if (position == POS_CHECK_A) begin
              got_check_a_next = data_byte;
              position_next    = position + POS_W'(1);
            end else begin
              // last frame byte: check B, verdict
              armed_next    = 1'b0;
              position_next = POS_SYNC_FIRST;
              res_valid     = 1'b1;
              if (got_ack_id == 8'd0) begin
                res_status = STATUS_NAK;
              end else if (got_class == want_class && got_msg_id == want_id &&
                           got_check_a == sum_a && data_byte == sum_b) begin
                res_status = STATUS_OK;
              end else begin
                res_status = STATUS_MISMATCH;
              end
            end
          end
        end
        default: begin
          // unused kind, no effect
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // state registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      armed       <= 1'b0;
      position    <= POS_SYNC_FIRST;
      elapsed_ms  <= '0;
      want_class  <= '0;
      want_id     <= '0;
      sum_a       <= '0;
      sum_b       <= '0;
      got_ack_id  <= 8'd1;
      got_class   <= '0;
      got_msg_id  <= '0;
      got_check_a <= '0;
    end else begin
      armed       <= armed_next;
      position    <= position_next;
      elapsed_ms  <= elapsed_ms_next;
      want_class  <= want_class_next;
      want_id     <= want_id_next;
      sum_a       <= sum_a_next;
      sum_b       <= sum_b_next;
      got_ack_id  <= got_ack_id_next;
      got_class   <= got_class_next;
      got_msg_id  <= got_msg_id_next;
      got_check_a <= got_check_a_next;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms  <= TIMEOUT_MS_RST;
      sync_first  <= SYNC_FIRST_RST;
      sync_second <= SYNC_SECOND_RST;
      ack_class   <= ACK_CLASS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TIMEOUT_MS:  timeout_ms  <= cfg_data;
        REG_SYNC_FIRST:  sync_first  <= cfg_data[7:0];
        REG_SYNC_SECOND: sync_second <= cfg_data[7:0];
        REG_ACK_CLASS:   ack_class   <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // result buffer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      // output free next cycle: skid entry first, else the fresh result
      out_valid  <= skid_valid || res_valid;
      skid_valid <= 1'b0;
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      status <= skid_valid ? skid_status : res_status;
    end else if (res_valid) begin
      skid_status <= res_status;
    end
  end

endmodule

// File: src/ubx_ack_frame_checker_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ubxack_chk
// port-level checks of the acknowledge frame checker
// ----------------------------------------------------------------------------
module ubxack_chk
  import ubxack_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] kind,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] status
);

  // a held result beat keeps its value
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status))
    else $error("result beat changed while stalled");

  // a result beat appears only after an accepted item
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result beat without an item");

  // a start never yields a result
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && kind == KIND_START && !out_valid |=> !out_valid)
    else $error("start produced a result");

  // input stalls only with a result waiting
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output");

endmodule

bind ubx_ack_frame_checker ubxack_chk u_ubxack_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .kind      (kind),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .status    (status)
);
